// ----- src/slbm_pkg.sv -----
// Shared types and constants for the serial loaded bank mapper.
// No dependencies; imported by every module of the block.
package slbm_pkg;

  // Access kinds
  localparam logic [1:0] OP_CPU_READ  = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [1:0] OP_PPU_READ  = 2'd2;
  localparam logic [1:0] OP_PPU_WRITE = 2'd3;

  // Target memories
  localparam logic [2:0] TGT_NONE    = 3'd0;
  localparam logic [2:0] TGT_PRG_RAM = 3'd1;
  localparam logic [2:0] TGT_PRG_ROM = 3'd2;
  localparam logic [2:0] TGT_CHR_ROM = 3'd3;
  localparam logic [2:0] TGT_CHR_RAM = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHR_COUNT = 2'd1;

  // Internal register select, address bits 14..13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // PRG modes, control bits 3..2; modes 0 and 1 both map one 32K bank
  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  // Address windows and reset values
  localparam logic [15:0] PRG_RAM_BASE   = 16'h6000;
  localparam logic [15:0] PRG_ROM_BASE   = 16'h8000;
  localparam logic [15:0] PPU_PATTERN_TOP = 16'h1FFF;
  localparam int          PRG_RAM_BYTES  = 8192;
  localparam logic [18:0] PRG_RAM_MASK   = 19'(PRG_RAM_BYTES - 1);
  localparam logic [4:0]  CONTROL_RESET  = 5'h1C;
  localparam logic [4:0]  PRG_MODE3_BITS = 5'h0C;
  localparam logic [1:0]  MIRROR_RESET   = 2'd3;
  localparam logic [5:0]  PRG_COUNT_RESET = 6'd16;
  localparam logic [5:0]  CHR_COUNT_RESET = 6'd0;
  localparam logic [2:0]  LOAD_LAST      = 3'd4;

  // One bus access
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
  } access_t;

  // Mapper register file as seen by the decoder
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg_sel;
    logic [5:0] prg_count;
    logic [5:0] chr_count;
  } regs_t;

  // One result word
  typedef struct packed {
    logic        handled;
    logic [2:0]  target;
    logic [18:0] mem_offset;
    logic        mem_write;
    logic [1:0]  mirroring;
  } result_t;

endpackage

// ----- src/slbm_regs.sv -----
// Serial load shifter, mapper registers and configuration registers.
// Depends on slbm_pkg.
module slbm_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  slbm_pkg::access_t acc,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [5:0]       cfg_data,
  output slbm_pkg::regs_t  regs,
  output logic [1:0]       mirror_next
);
  import slbm_pkg::*;

  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_reg, control_reg_next;
  logic [4:0] chr_select_low, chr_select_low_next;
  logic [4:0] chr_select_high, chr_select_high_next;
  logic [4:0] prg_select, prg_select_next;
  logic [1:0] mirror_mode;
  logic [5:0] prg_bank_count, chr_bank_count;
  logic [4:0] loaded;
  logic       reg_write;

  assign reg_write = (acc.opcode == OP_CPU_WRITE) && (acc.bus_addr >= PRG_ROM_BASE);
  assign loaded    = {acc.write_data[0], shift_value[4:1]};

  // Serial load and register update for one word
  always_comb begin
    shift_value_next     = shift_value;
    shift_count_next     = shift_count;
    control_reg_next     = control_reg;
    chr_select_low_next  = chr_select_low;
    chr_select_high_next = chr_select_high;
    prg_select_next      = prg_select;
    mirror_next          = mirror_mode;
    if (step && reg_write) begin
      if (acc.write_data[7]) begin
        shift_value_next = '0;
        shift_count_next = '0;
        control_reg_next = control_reg | PRG_MODE3_BITS;
      end else if (shift_count == LOAD_LAST) begin
        shift_value_next = '0;
        shift_count_next = '0;
        case (acc.bus_addr[14:13])
          SEL_CONTROL: begin
            control_reg_next = loaded;
            mirror_next      = loaded[1:0];
          end
          SEL_CHR_LOW:  chr_select_low_next  = loaded;
          SEL_CHR_HIGH: chr_select_high_next = loaded;
          default:      prg_select_next      = loaded;
        endcase
      end else begin
        shift_value_next = loaded;
        shift_count_next = shift_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value     <= '0;
      shift_count     <= '0;
      control_reg     <= CONTROL_RESET;
      chr_select_low  <= '0;
      chr_select_high <= '0;
      prg_select      <= '0;
      mirror_mode     <= MIRROR_RESET;
    end else begin
      shift_value     <= shift_value_next;
      shift_count     <= shift_count_next;
      control_reg     <= control_reg_next;
      chr_select_low  <= chr_select_low_next;
      chr_select_high <= chr_select_high_next;
      prg_select      <= prg_select_next;
      mirror_mode     <= mirror_next;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_bank_count <= CHR_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_COUNT: prg_bank_count <= cfg_data;
        CFG_CHR_COUNT: chr_bank_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign regs = '{control:   control_reg,
                  chr_low:   chr_select_low,
                  chr_high:  chr_select_high,
                  prg_sel:   prg_select,
                  prg_count: prg_bank_count,
                  chr_count: chr_bank_count};

  // A load never runs past the fifth bit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    shift_count <= LOAD_LAST)
    else $error("serial load count out of range");

  // A reset write always leaves PRG mode 3 behind
  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    step && reg_write && acc.write_data[7] |=> control_reg[3:2] == 2'b11 && shift_count == 3'd0)
    else $error("reset write did not force PRG mode 3");

  // Five plain writes complete a load
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    step && reg_write && !acc.write_data[7] && shift_count == LOAD_LAST
      |=> shift_count == 3'd0 && shift_value == 5'd0)
    else $error("completed load did not clear the shifter");

endmodule

// ----- src/slbm_decode.sv -----
// Address decode and bank translation for one access.
// Depends on slbm_pkg; purely combinational.
module slbm_decode (
  input  slbm_pkg::access_t acc,
  input  slbm_pkg::regs_t   regs,
  input  logic [1:0]        mirror,
  output slbm_pkg::result_t res
);
  import slbm_pkg::*;

  logic [4:0]  prg_page;
  logic [4:0]  last_bank;
  logic [4:0]  chr_sel;
  logic [18:0] prg_offset;
  logic [18:0] chr_offset;
  logic        upper;

  assign upper     = acc.bus_addr[14];
  assign last_bank = 5'(regs.prg_count - 6'd1);

  // PRG bank by mode, control bits 3..2
  always_comb begin
    case (regs.control[3:2])
      PRG_MODE_FIX_FIRST: prg_page = upper ? {1'b0, regs.prg_sel[3:0]} : 5'd0;
      PRG_MODE_FIX_LAST:  prg_page = upper ? last_bank : {1'b0, regs.prg_sel[3:0]};
      default:            prg_page = {1'b0, regs.prg_sel[3:1], upper};
    endcase
  end
  assign prg_offset = {prg_page, acc.bus_addr[13:0]};

  // CHR bank: 8K mode drops the low select bit, 4K mode picks by A12
  assign chr_sel = acc.bus_addr[12] ? regs.chr_high : regs.chr_low;
  assign chr_offset = regs.control[4] ? {2'b00, chr_sel, acc.bus_addr[11:0]}
                                      : {2'b00, regs.chr_low[4:1], acc.bus_addr[12:0]};

  always_comb begin
    res = '{handled: 1'b0, target: TGT_NONE, mem_offset: '0, mem_write: 1'b0,
            mirroring: mirror};
    if (!acc.opcode[1]) begin
      if (acc.bus_addr >= PRG_ROM_BASE) begin
        res.handled = 1'b1;
        if (acc.opcode == OP_CPU_READ) begin
          res.target     = TGT_PRG_ROM;
          res.mem_offset = prg_offset;
        end
      end else if (acc.bus_addr >= PRG_RAM_BASE) begin
        res.handled    = 1'b1;
        res.target     = TGT_PRG_RAM;
        res.mem_offset = {3'b000, acc.bus_addr} & PRG_RAM_MASK;
        res.mem_write  = (acc.opcode == OP_CPU_WRITE);
      end
    end else if (acc.bus_addr <= PPU_PATTERN_TOP) begin
      if (regs.chr_count == 6'd0) begin
        res.handled    = 1'b1;
        res.target     = TGT_CHR_RAM;
        res.mem_offset = {6'b0, acc.bus_addr[12:0]};
        res.mem_write  = (acc.opcode == OP_PPU_WRITE);
      end else if (acc.opcode == OP_PPU_READ) begin
        res.handled    = 1'b1;
        res.target     = TGT_CHR_ROM;
        res.mem_offset = chr_offset;
      end
    end
  end

endmodule

// ----- src/serial_loaded_bank_mapper.sv -----
// Serial loaded bank mapper: one word per cycle sustained while out_ready holds; an
// accepted word passes the input register, decode and register update, then the
// result register. in_ready is high while the input stage is empty or the result
// register frees in the same cycle.
// Synchronous active-high reset empties both stages and loads the register reset
// values (control 0x1C, mirroring horizontal, 16 PRG banks, CHR RAM).
module serial_loaded_bank_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] bus_addr,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        handled,
  output logic [2:0]  target,
  output logic [18:0] mem_offset,
  output logic        mem_write,
  output logic [1:0]  mirroring,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import slbm_pkg::*;

  logic    s1_valid;
  access_t s1_acc;
  logic    out_free;
  logic    step;
  regs_t   regs;
  logic [1:0] mirror_next;
  result_t res_next;
  result_t res;

  // Pipeline flow control
  assign out_free  = !out_valid || out_ready;
  assign step      = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_acc <= '{opcode: opcode, bus_addr: bus_addr, write_data: write_data};
    end
  end

  slbm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .acc        (s1_acc),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .regs       (regs),
    .mirror_next(mirror_next)
  );

  slbm_decode u_decode (
    .acc   (s1_acc),
    .regs  (regs),
    .mirror(mirror_next),
    .res   (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign handled    = res.handled;
  assign target     = res.target;
  assign mem_offset = res.mem_offset;
  assign mem_write  = res.mem_write;
  assign mirroring  = res.mirroring;

  // Unclaimed or register words carry no offset and no write
  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_NONE |-> mem_offset == 19'd0 && !mem_write)
    else $error("idle target with offset or write");

  // Only RAM targets are written
  a_write_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_write |-> target == TGT_PRG_RAM || target == TGT_CHR_RAM)
    else $error("write to a ROM target");

  // A word leaves the input stage only into a free result slot
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && s1_valid |=> out_valid && s1_valid)
    else $error("word lost under stall");

  // Unclaimed words never name a target
  a_unhandled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !handled |-> target == TGT_NONE)
    else $error("unclaimed word with a target");

endmodule

// ----- tb/sv/slbm_access_checker.sv -----
// Scoreboard for the serial loaded bank mapper: watches the access, result and
// register write channels, predicts every result word and compares it field by field.
// Depends on slbm_pkg.
module slbm_access_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] bus_addr,
  input  logic [7:0]  write_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        handled,
  input  logic [2:0]  target,
  input  logic [18:0] mem_offset,
  input  logic        mem_write,
  input  logic [1:0]  mirroring,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  output int          error_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import slbm_pkg::*;

  // Mapper state as the predictor sees it
  logic [4:0] load_shift;
  logic [2:0] load_count;
  logic [4:0] control;
  logic [4:0] chr_low;
  logic [4:0] chr_high;
  logic [4:0] prg_sel;
  logic [1:0] mirror;
  logic [5:0] prg_count;
  logic [5:0] chr_count;

  result_t expected_words[$];

  function automatic logic [18:0] prg_rom_offset(input logic [15:0] addr);
    logic [5:0] last;
    logic [4:0] bank;
    last = prg_count - 6'd1;
    case (control[3:2])
      PRG_MODE_FIX_FIRST: bank = addr[14] ? {1'b0, prg_sel[3:0]} : 5'd0;
      PRG_MODE_FIX_LAST:  bank = addr[14] ? last[4:0] : {1'b0, prg_sel[3:0]};
      default:            bank = {1'b0, prg_sel[3:1], addr[14]};  // 32K mode
    endcase
    return {bank, addr[13:0]};
  endfunction

  function automatic logic [18:0] chr_rom_offset(input logic [15:0] addr);
    // 8K mode drops the low bit of the bank select
    if (!control[4])
      return {2'b00, chr_low[4:1], addr[12:0]};
    else if (addr[12])
      return {2'b00, chr_high, addr[11:0]};
    else
      return {2'b00, chr_low, addr[11:0]};
  endfunction

  // Serial load port: one bit per write, LSB first; bit 7 clears and forces mode 3
  function automatic void load_bit(input logic [15:0] addr, input logic [7:0] data);
    if (data[7]) begin
      load_shift = '0;
      load_count = '0;
      control    = control | PRG_MODE3_BITS;
    end else begin
      load_shift = {data[0], load_shift[4:1]};
      if (load_count == LOAD_LAST) begin
        case (addr[14:13])
          SEL_CONTROL: begin
            control = load_shift;
            mirror  = load_shift[1:0];
          end
          SEL_CHR_LOW:  chr_low  = load_shift;
          SEL_CHR_HIGH: chr_high = load_shift;
          default:      prg_sel  = load_shift;
        endcase
        load_shift = '0;
        load_count = '0;
      end else begin
        load_count = load_count + 3'd1;
      end
    end
  endfunction

  function automatic result_t map_access(input logic [1:0] op, input logic [15:0] addr,
                                         input logic [7:0] data);
    result_t r;
    r = '0;
    if (op == OP_CPU_READ || op == OP_CPU_WRITE) begin
      if (addr >= PRG_ROM_BASE) begin
        r.handled = 1'b1;
        if (op == OP_CPU_WRITE) begin
          load_bit(addr, data);
        end else begin
          r.target     = TGT_PRG_ROM;
          r.mem_offset = prg_rom_offset(addr);
        end
      end else if (addr >= PRG_RAM_BASE) begin
        r.handled    = 1'b1;
        r.target     = TGT_PRG_RAM;
        r.mem_offset = {3'b000, addr} & PRG_RAM_MASK;
        r.mem_write  = (op == OP_CPU_WRITE);
      end
    end else if (addr <= PPU_PATTERN_TOP) begin
      if (chr_count == 6'd0) begin
        // no CHR ROM: flat 8K of CHR RAM, writable
        r.handled    = 1'b1;
        r.target     = TGT_CHR_RAM;
        r.mem_offset = {6'd0, addr[12:0]};
        r.mem_write  = (op == OP_PPU_WRITE);
      end else if (op == OP_PPU_READ) begin
        r.handled    = 1'b1;
        r.target     = TGT_CHR_ROM;
        r.mem_offset = chr_rom_offset(addr);
      end
    end
    // mirroring reflects the state after this word's update
    r.mirroring = mirror;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [18:0] want,
                                      input logic [18:0] got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    result_t want;
    if (rst) begin
      load_shift = '0;
      load_count = '0;
      control    = CONTROL_RESET;
      chr_low    = '0;
      chr_high   = '0;
      prg_sel    = '0;
      mirror     = MIRROR_RESET;
      prg_count  = PRG_COUNT_RESET;
      chr_count  = CHR_COUNT_RESET;
      error_count = 0;
      expected_words.delete();
    end else begin
      // register writes are to land only while the block is idle; the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_COUNT)
          prg_count = cfg_data;
        else if (cfg_index == CFG_CHR_COUNT)
          chr_count = cfg_data;
      end
      // retire the oldest expectation against the result word
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no access waiting");
          error_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("handled", 19'(want.handled), 19'(handled));
          check_field("target", 19'(want.target), 19'(target));
          check_field("mem_offset", want.mem_offset, mem_offset);
          check_field("mem_write", 19'(want.mem_write), 19'(mem_write));
          check_field("mirroring", 19'(want.mirroring), 19'(mirroring));
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(map_access(opcode, bus_addr, write_data));
    end
    pending_words = expected_words.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the serial loaded bank mapper regression: clock, reset, access stimulus,
// register writes, result back-pressure and the verdict.
// Depends on slbm_pkg, serial_loaded_bank_mapper and slbm_access_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slbm_pkg::*;

  localparam int          TIMEOUT_NS    = 200000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          DRAIN_LIMIT   = 1000;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          SEG_WORDS     = 104;
  localparam logic [7:0]  LOAD_RESET    = 8'h80;
  localparam logic [1:0]  CFG_SPARE_A   = 2'd2;  // unmapped register indexes
  localparam logic [1:0]  CFG_SPARE_B   = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [15:0] bus_addr;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_ready;
  logic        handled;
  logic [2:0]  target;
  logic [18:0] mem_offset;
  logic        mem_write;
  logic [1:0]  mirroring;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  int   error_count;
  int   pending_words;
  int   words_sent = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_off_req = 1'b0;

  // Bank counts per segment; extremes included
  int prg_plan [8] = '{16, 32, 1, 63, 0, 33, 7, 20};
  int chr_plan [8] = '{0, 32, 0, 63, 32, 1, 4, 0};

  serial_loaded_bank_mapper i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .bus_addr(bus_addr), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .handled(handled), .target(target), .mem_offset(mem_offset),
    .mem_write(mem_write), .mirroring(mirroring),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  slbm_access_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .bus_addr(bus_addr), .write_data(write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .handled(handled), .target(target), .mem_offset(mem_offset),
    .mem_write(mem_write), .mirroring(mirroring),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_words(pending_words)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int held;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && held < HOLD_CYCLES) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        if (!hold_off_req)
          held = 0;
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one access word; returns at the falling edge after it is taken
  task automatic send_word(input logic [1:0] op, input logic [15:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    bus_addr   <= addr;
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Five serial writes; break_at >= 0 slips a reset write in before that bit
  task automatic serial_load(input logic [1:0] sel, input logic [4:0] value,
                             input int break_at);
    logic [15:0] addr;
    for (int i = 0; i < 5; i++) begin
      if (i == break_at)
        send_word(OP_CPU_WRITE, PRG_ROM_BASE | 16'($urandom), LOAD_RESET | 8'($urandom));
      addr = (i == 4) ? {1'b1, sel, 13'($urandom)} : (PRG_ROM_BASE | 16'($urandom));
      send_word(OP_CPU_WRITE, addr, {1'b0, 6'($urandom), value[i]});
    end
  endtask

  task automatic send_random_access();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      serial_load(2'($urandom), 5'($urandom),
                  ($urandom_range(7) == 0) ? int'($urandom_range(4)) : -1);
    else if (pick < 38)
      send_word(OP_CPU_WRITE, PRG_ROM_BASE | 16'($urandom), LOAD_RESET | 8'($urandom));
    else if (pick < 55)
      send_word(OP_CPU_READ, PRG_ROM_BASE | 16'($urandom), 8'($urandom));
    else if (pick < 65)
      send_word($urandom_range(1) ? OP_CPU_WRITE : OP_CPU_READ,
                PRG_RAM_BASE | {3'b000, 13'($urandom)}, 8'($urandom));
    else if (pick < 85)
      send_word($urandom_range(1) ? OP_PPU_WRITE : OP_PPU_READ,
                {3'b000, 13'($urandom)}, 8'($urandom));
    else
      send_word(2'($urandom), 16'($urandom), 8'($urandom));  // noise
  endtask

  // Stop offering and let every outstanding word come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes keep one assignment per edge
  task automatic cfg_write(input logic [1:0] idx, input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int seg_end;
    int drain;
    rst        = 1'b1;
    in_valid   = 1'b0;
    opcode     = OP_CPU_READ;
    bus_addr   = '0;
    write_data = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_PRG_COUNT;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: window edges, CHR RAM, partial and reset-broken loads
    send_word(OP_CPU_READ, 16'h0000, 8'h00);
    send_word(OP_CPU_WRITE, 16'h5FFF, 8'hFF);
    send_word(OP_CPU_READ, PRG_RAM_BASE, 8'h00);
    send_word(OP_CPU_WRITE, 16'h7FFF, 8'h5A);
    send_word(OP_CPU_READ, 16'hFFFF, 8'h00);
    send_word(OP_PPU_READ, 16'h0000, 8'h00);
    send_word(OP_PPU_WRITE, PPU_PATTERN_TOP, 8'hA5);
    send_word(OP_PPU_READ, 16'h2000, 8'h00);
    send_word(OP_PPU_WRITE, 16'hFFFF, 8'hFF);
    send_word(OP_CPU_WRITE, PRG_ROM_BASE, 8'h01);
    send_word(OP_CPU_WRITE, PRG_ROM_BASE, 8'h00);
    send_word(OP_CPU_WRITE, 16'hBFFF, LOAD_RESET);
    // 4K CHR, 32K PRG, vertical mirroring
    serial_load(SEL_CONTROL, 5'h12, -1);
    send_word(OP_CPU_READ, 16'hC000, 8'h00);

    // Directed: CHR ROM present, zero PRG banks so the last bank wraps
    wait_idle();
    cfg_write(CFG_PRG_COUNT, 6'd0);
    cfg_write(CFG_CHR_COUNT, 6'd1);
    cfg_valid <= 1'b0;
    send_word(OP_PPU_WRITE, 16'h0000, 8'h3C);
    send_word(OP_PPU_READ, PPU_PATTERN_TOP, 8'h00);
    send_word(OP_CPU_WRITE, PRG_ROM_BASE, LOAD_RESET);
    send_word(OP_CPU_READ, 16'hC000, 8'h00);
    send_word(OP_CPU_READ, PRG_ROM_BASE, 8'h00);

    // Random segments, each with its own bank counts and idling mix
    for (int seg = 0; seg < 8; seg++) begin
      wait_idle();
      cfg_write(CFG_PRG_COUNT, 6'(prg_plan[seg]));
      cfg_write(CFG_CHR_COUNT, 6'(chr_plan[seg]));
      cfg_write(seg[0] ? CFG_SPARE_A : CFG_SPARE_B, 6'($urandom));
      cfg_valid <= 1'b0;
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 54; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 54; end
        default: begin idle_pct = 29; stall_pct <= 29; end
      endcase
      seg_end = words_sent + SEG_WORDS;

      // long receiver hold-off while the sender keeps pushing
      if (seg == 0) begin
        hold_off_req <= 1'b1;
        repeat (40) send_random_access();
        hold_off_req <= 1'b0;
      end

      while (words_sent < seg_end - SEG_WORDS / 2) send_random_access();
      // sender pauses until every result is back
      wait_idle();
      while (words_sent < seg_end) send_random_access();
    end

    // Drain and verdict
    in_valid <= 1'b0;
    drain = 0;
    while (pending_words != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_words == 0) begin
      $display("serial_loaded_bank_mapper regression: pass");
    end else begin
      if (pending_words != 0)
        $error("%0d result words never arrived", pending_words);
      $display("serial_loaded_bank_mapper regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("serial_loaded_bank_mapper regression: fail");
    $finish;
  end

endmodule
